### rtl/core/dswc_pkg.sv
// shared types, constants and register codes of the display sleep/wake controller
package dswc_pkg;

    localparam int TIME_BITS = 32;
    localparam int Z_BITS    = 16;

    localparam int TIMEOUT_W = 32;
    localparam int THRESH_W  = 16;
    localparam int SETTLE_W  = 16;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_AW-1:0] REG_IDLE_TIMEOUT  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RAISE_WAKE_EN = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TILT_PRESENT  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RAISE_THRESH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RELEASE_THRESH = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SETTLE_TIME   = 3'd5;

    // reported wrist phase codes
    localparam logic [1:0] PHASE_DOWN     = 2'd0;
    localparam logic [1:0] PHASE_SETTLING = 2'd1;
    localparam logic [1:0] PHASE_RAISED   = 2'd2;

    typedef enum logic [2:0] {
        POSE_DOWN   = 3'b001,
        POSE_SETTLE = 3'b010,
        POSE_UP     = 3'b100
    } wrist_state_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0]       idle_timeout_ms;
        logic                       raise_wake_enable;
        logic                       tilt_sensor_present;
        logic signed [THRESH_W-1:0] raise_threshold;
        logic signed [THRESH_W-1:0] release_threshold;
        logic [SETTLE_W-1:0]        settle_time_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               touched;
        logic               button_click;
        logic               gravity_valid;
        logic signed [15:0] accel_z;
    } item_t;

    typedef struct packed {
        logic       asleep;
        logic       wake_pulse;
        logic       sleep_pulse;
        logic [1:0] wrist_phase;
    } result_t;

    typedef struct packed {
        wrist_state_t         mode;
        logic [TIME_BITS-1:0] settle_start;
        logic                 raised_now;
    } wrist_next_t;

endpackage

### rtl/core/dswc_wrist.sv
// wrist-raise detector: next detector state for one gravity sample
module dswc_wrist
    import dswc_pkg::*;
(
    input  wrist_state_t               mode_cur,
    input  logic [TIME_BITS-1:0]       settle_start_cur,
    input  logic [TIME_BITS-1:0]       now_t,
    input  logic signed [Z_BITS-1:0]   z,
    input  cfg_t                       cfg,
    output wrist_next_t                nxt
);

    logic [TIME_BITS-1:0] settle_elapsed;

    assign settle_elapsed = now_t - settle_start_cur;

    always_comb begin
        nxt.mode         = mode_cur;
        nxt.settle_start = settle_start_cur;
        nxt.raised_now   = 1'b0;
        unique case (mode_cur)
            POSE_SETTLE: begin
                if (z <= cfg.raise_threshold) begin
                    nxt.mode = POSE_DOWN;
                end else if (settle_elapsed >= cfg.settle_time_ms) begin
                    nxt.mode       = POSE_UP;
                    nxt.raised_now = 1'b1;
                end
            end
            POSE_UP: begin
                if (z < cfg.release_threshold) begin
                    nxt.mode = POSE_DOWN;
                end
            end
            default: begin
                nxt.mode = POSE_DOWN;
                if (z > cfg.raise_threshold) begin
                    nxt.mode         = POSE_SETTLE;
                    nxt.settle_start = now_t;
                end
            end
        endcase
    end

endmodule

### rtl/core/dswc_core.sv
// controller state and per-item event logic
module dswc_core
    import dswc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    timeout_wr,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic                 sleeping_reg, sleeping_next;
    logic [TIME_BITS-1:0] last_act_reg, last_act_next;
    wrist_state_t         mode_reg;
    logic [TIME_BITS-1:0] settle_start_reg;
    logic                 raise_seen_reg, raise_seen_next;
    logic                 restart_reg;

    logic [TIME_BITS-1:0]     now_t;
    logic signed [Z_BITS-1:0] z;
    logic                     run_det;
    wrist_next_t              det;
    wrist_state_t             mode_next;
    logic [TIME_BITS-1:0]     settle_start_next;
    logic                     seen_mid;
    logic                     wake_req;
    logic                     sleep_p;
    logic                     wake_p;
    logic                     awake_mid;
    logic [TIME_BITS-1:0]     idle_elapsed;
    logic [TIME_BITS-1:0]     last_mid;

    assign now_t = TIME_BITS'(item.now_ms);
    assign z     = item.accel_z[Z_BITS-1:0];

    dswc_wrist u_wrist (
        .mode_cur         (mode_reg),
        .settle_start_cur (settle_start_reg),
        .now_t            (now_t),
        .z                (z),
        .cfg              (cfg),
        .nxt              (det)
    );

    assign run_det           = cfg.tilt_sensor_present & item.gravity_valid;
    assign mode_next         = run_det ? det.mode : mode_reg;
    assign settle_start_next = run_det ? det.settle_start : settle_start_reg;
    assign seen_mid          = raise_seen_reg | (run_det & det.raised_now);

    always_comb begin
        // a timeout write restarts the countdown before anything else
        last_mid        = restart_reg ? now_t : last_act_reg;
        wake_req        = 1'b0;
        sleep_p         = 1'b0;
        raise_seen_next = seen_mid;
        awake_mid       = ~sleeping_reg;
        if (item.button_click) begin
            if (sleeping_reg) begin
                wake_req = 1'b1;
            end else begin
                awake_mid = 1'b0;
                sleep_p   = 1'b1;
            end
            last_mid = now_t;
        end else if (item.touched) begin
            wake_req = 1'b1;
            last_mid = now_t;
        end else if (cfg.tilt_sensor_present && seen_mid) begin
            raise_seen_next = 1'b0;
            if (cfg.raise_wake_enable) begin
                wake_req = 1'b1;
                last_mid = now_t;
            end
        end
        wake_p = wake_req & sleeping_reg;
        if (wake_p) begin
            awake_mid = 1'b1;
        end
        last_act_next = last_mid;
        idle_elapsed  = now_t - last_mid;
        sleeping_next = ~awake_mid;
        if (awake_mid && (cfg.idle_timeout_ms != '0) &&
            (idle_elapsed >= cfg.idle_timeout_ms)) begin
            sleeping_next = 1'b1;
            sleep_p       = 1'b1;
        end
    end

    always_comb begin
        res.asleep      = sleeping_next;
        res.wake_pulse  = wake_p;
        res.sleep_pulse = sleep_p;
        unique case (mode_next)
            POSE_SETTLE: res.wrist_phase = PHASE_SETTLING;
            POSE_UP:     res.wrist_phase = PHASE_RAISED;
            default:     res.wrist_phase = PHASE_DOWN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleeping_reg     <= 1'b0;
            last_act_reg     <= '0;
            mode_reg         <= POSE_DOWN;
            settle_start_reg <= '0;
            raise_seen_reg   <= 1'b0;
            restart_reg      <= 1'b0;
        end else begin
            if (step) begin
                sleeping_reg     <= sleeping_next;
                last_act_reg     <= last_act_next;
                mode_reg         <= mode_next;
                settle_start_reg <= settle_start_next;
                raise_seen_reg   <= raise_seen_next;
                restart_reg      <= 1'b0;
            end
            if (timeout_wr) begin
                restart_reg <= 1'b1;
            end
        end
    end

endmodule

### rtl/core/display_sleep_wake_controller_unit.sv
// top level of the display sleep/wake controller: ports, config registers, item and result registers
//
//  channel   | ports                              | content
//  ----------+------------------------------------+-----------------------------------------
//  input     | s_tvalid s_tready s_tdata s_tuser  | one control loop pass (time, touch, button, z)
//  result    | m_tvalid m_tready m_tdata          | sleep state, wake/sleep pulses, wrist phase
//  config    | cfg_wr_en cfg_addr cfg_wr_data     | register writes, no read-back
//
// one item per cycle sustained while m_tready stays high; a transfer lands in the item register, is
// evaluated against the state registers once the result register can load and is captured in the
// result register, so m_tvalid follows the input transfer through the item and result registers
// the result register frees up in the same cycle that m_tready takes it, so the
// input side only stalls when both item and result registers are full and m_tready is low
// reset is synchronous, active low; state clears and config registers take their defaults
module display_sleep_wake_controller_unit
    import dswc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], touched[32], button_click[33], accel_z[49:34], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // gravity_valid[0]
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // asleep[0], wake_pulse[1], sleep_pulse[2], wrist_phase[4:3], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_wr_en,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_DW-1:0]     cfg_wr_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;

    result_t res_comb;
    logic    res_free;
    logic    step;
    logic    timeout_wr;
    logic    in_xfer;

    // handshake: result register can load when empty or being drained
    assign res_free = ~res_valid_reg | m_tready;
    assign step     = item_valid_reg & res_free;
    assign s_tready = ~item_valid_reg | step;
    assign in_xfer  = s_tvalid & s_tready;

    // configuration write decode
    assign timeout_wr = cfg_wr_en && (cfg_addr == REG_IDLE_TIMEOUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_timeout_ms     <= TIMEOUT_W'(30000);
            cfg_reg.raise_wake_enable   <= 1'b1;
            cfg_reg.tilt_sensor_present <= 1'b1;
            cfg_reg.raise_threshold     <= THRESH_W'(8000);
            cfg_reg.release_threshold   <= THRESH_W'(4000);
            cfg_reg.settle_time_ms      <= SETTLE_W'(300);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IDLE_TIMEOUT:   cfg_reg.idle_timeout_ms     <= cfg_wr_data[TIMEOUT_W-1:0];
                REG_RAISE_WAKE_EN:  cfg_reg.raise_wake_enable   <= cfg_wr_data[0];
                REG_TILT_PRESENT:   cfg_reg.tilt_sensor_present <= cfg_wr_data[0];
                REG_RAISE_THRESH:   cfg_reg.raise_threshold     <= cfg_wr_data[THRESH_W-1:0];
                REG_RELEASE_THRESH: cfg_reg.release_threshold   <= cfg_wr_data[THRESH_W-1:0];
                REG_SETTLE_TIME:    cfg_reg.settle_time_ms      <= cfg_wr_data[SETTLE_W-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg.now_ms        <= s_tdata[31:0];
            item_reg.touched       <= s_tdata[32];
            item_reg.button_click  <= s_tdata[33];
            item_reg.accel_z       <= s_tdata[49:34];
            item_reg.gravity_valid <= s_tuser;
        end
    end

    dswc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .timeout_wr (timeout_wr),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .res        (res_comb)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (res_free) begin
            res_valid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {3'b000, res_reg.wrist_phase, res_reg.sleep_pulse,
                       res_reg.wake_pulse, res_reg.asleep};

endmodule

### tb/display_sleep_wake_controller_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the display sleep/wake controller: directed passes, then random phases

// tracks the screen and wrist state of the controller and holds the status words still to come
class display_state_tracker;
    dswc_pkg::cfg_t    cfg;
    logic              sleeping;
    logic [31:0]       last_activity;
    logic [1:0]        wrist_mode;
    logic [31:0]       settle_start;
    logic              raise_seen;
    logic              restart_pending;
    dswc_pkg::result_t expected_status[$];
    int                mismatches;
    int                orphans;
    int                reported;
    int                checked;
    int                wakes;
    int                sleeps;
    int                raises;

    function new();
        cfg.idle_timeout_ms     = 32'd30000;
        cfg.raise_wake_enable   = 1'b1;
        cfg.tilt_sensor_present = 1'b1;
        cfg.raise_threshold     = 16'sd8000;
        cfg.release_threshold   = 16'sd4000;
        cfg.settle_time_ms      = 16'd300;
        sleeping        = 1'b0;
        last_activity   = '0;
        wrist_mode      = dswc_pkg::PHASE_DOWN;
        settle_start    = '0;
        raise_seen      = 1'b0;
        restart_pending = 1'b0;
        mismatches = 0;
        orphans    = 0;
        reported   = 0;
        checked    = 0;
        wakes      = 0;
        sleeps     = 0;
        raises     = 0;
    endfunction

    function void write_reg(logic [dswc_pkg::CFG_AW-1:0] idx, logic [dswc_pkg::CFG_DW-1:0] val);
        case (idx)
            dswc_pkg::REG_IDLE_TIMEOUT: begin
                cfg.idle_timeout_ms = val;
                restart_pending     = 1'b1;
            end
            dswc_pkg::REG_RAISE_WAKE_EN:  cfg.raise_wake_enable   = val[0];
            dswc_pkg::REG_TILT_PRESENT:   cfg.tilt_sensor_present = val[0];
            dswc_pkg::REG_RAISE_THRESH:   cfg.raise_threshold     = val[15:0];
            dswc_pkg::REG_RELEASE_THRESH: cfg.release_threshold   = val[15:0];
            dswc_pkg::REG_SETTLE_TIME:    cfg.settle_time_ms      = val[15:0];
            default: ;
        endcase
    endfunction

    // one loop pass accepted: work out the status word it must produce
    function void note_loop_pass(dswc_pkg::item_t pass_item);
        dswc_pkg::result_t  st;
        logic               wake_req;
        logic signed [15:0] z;
        logic [31:0]        now;
        logic [31:0]        since;
        now      = pass_item.now_ms;
        z        = pass_item.accel_z;
        wake_req = 1'b0;
        st       = '0;
        if (restart_pending) begin
            last_activity   = now;
            restart_pending = 1'b0;
        end
        if (cfg.tilt_sensor_present && pass_item.gravity_valid) begin
            since = now - settle_start;
            case (wrist_mode)
                dswc_pkg::PHASE_SETTLING: begin
                    if (z <= $signed(cfg.raise_threshold)) begin
                        wrist_mode = dswc_pkg::PHASE_DOWN;
                    end else if (since >= {16'd0, cfg.settle_time_ms}) begin
                        wrist_mode = dswc_pkg::PHASE_RAISED;
                        raise_seen = 1'b1;
                        raises++;
                    end
                end
                dswc_pkg::PHASE_RAISED: begin
                    if (z < $signed(cfg.release_threshold))
                        wrist_mode = dswc_pkg::PHASE_DOWN;
                end
                default: begin
                    wrist_mode = dswc_pkg::PHASE_DOWN;
                    if (z > $signed(cfg.raise_threshold)) begin
                        wrist_mode   = dswc_pkg::PHASE_SETTLING;
                        settle_start = now;
                    end
                end
            endcase
        end
        if (pass_item.button_click) begin
            if (sleeping) begin
                wake_req = 1'b1;
            end else begin
                sleeping       = 1'b1;
                st.sleep_pulse = 1'b1;
            end
            last_activity = now;
        end else if (pass_item.touched) begin
            wake_req      = 1'b1;
            last_activity = now;
        end else if (cfg.tilt_sensor_present && raise_seen) begin
            raise_seen = 1'b0;
            if (cfg.raise_wake_enable) begin
                wake_req      = 1'b1;
                last_activity = now;
            end
        end
        if (wake_req && sleeping) begin
            sleeping      = 1'b0;
            st.wake_pulse = 1'b1;
        end
        if (!sleeping && cfg.idle_timeout_ms != 0 &&
            (now - last_activity) >= cfg.idle_timeout_ms) begin
            sleeping       = 1'b1;
            st.sleep_pulse = 1'b1;
        end
        st.asleep      = sleeping;
        st.wrist_phase = wrist_mode;
        if (st.wake_pulse)
            wakes++;
        if (st.sleep_pulse)
            sleeps++;
        expected_status.push_back(st);
    endfunction

    // one status word left the block: compare with the oldest one waiting
    function void check_status(logic [dswc_pkg::M_TDATA_W-1:0] raw);
        dswc_pkg::result_t want;
        dswc_pkg::result_t got;
        logic [2:0]        fill;
        got.asleep      = raw[0];
        got.wake_pulse  = raw[1];
        got.sleep_pulse = raw[2];
        got.wrist_phase = raw[4:3];
        fill            = raw[7:5];
        if (expected_status.size() == 0) begin
            orphans++;
            reported++;
            if (reported <= 10)
                $display("%0t: status word %b arrived with none expected", $realtime, raw);
            return;
        end
        want = expected_status.pop_front();
        checked++;
        if (got.asleep !== want.asleep || got.wake_pulse !== want.wake_pulse ||
            got.sleep_pulse !== want.sleep_pulse || got.wrist_phase !== want.wrist_phase ||
            fill !== 3'b000) begin
            mismatches++;
            reported++;
            if (reported <= 10)
                $display({"%0t: status %0d mismatch: asleep %b/%b wake %b/%b sleep %b/%b",
                          " phase %0d/%0d fill %b (exp/act)"},
                         $realtime, checked, want.asleep, got.asleep, want.wake_pulse,
                         got.wake_pulse, want.sleep_pulse, got.sleep_pulse,
                         want.wrist_phase, got.wrist_phase, fill);
        end
    endfunction

    function int pending();
        return expected_status.size();
    endfunction
endclass

module display_sleep_wake_controller_unit_test;
    import dswc_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 244;
    localparam int LATENCY_WAIT    = 4;      // covers the item and result registers plus margin
    localparam int WATCHDOG_LIMIT  = 2000;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_AW-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SPARE_7 = 3'd7;

    // pacing modes, one per phase in turn
    localparam int PACE_FREE     = 0;
    localparam int PACE_SENDER   = 1;
    localparam int PACE_RECEIVER = 2;
    localparam int PACE_BOTH     = 3;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr    = '0;
    logic [CFG_DW-1:0]    cfg_wr_data = '0;

    display_state_tracker tracker = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          items_sent     = 0;
    int          settings_used  = 1;     // reset defaults count as the first
    logic [31:0] clock_ms       = '0;    // running millisecond time of the random stimulus
    logic        wrist_up       = 1'b0;  // random stimulus: wrist held high or low
    cfg_t        cur_cfg;
    item_t       seen_item;

    display_sleep_wake_controller_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // monitor: inputs and outputs both sampled at the edge, before any update lands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen_item.now_ms        = s_tdata[31:0];
                seen_item.touched       = s_tdata[32];
                seen_item.button_click  = s_tdata[33];
                seen_item.accel_z       = s_tdata[49:34];
                seen_item.gravity_valid = s_tuser;
                tracker.note_loop_pass(seen_item);
                items_sent++;
            end
            if (m_tvalid && m_tready)
                tracker.check_status(m_tdata);
        end
    end

    // watchdog: too long without a transfer on either side ends the run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic item_t make_item(logic [31:0] now, logic touch, logic click,
                                        logic gvalid, logic [15:0] z);
        item_t r;
        r.now_ms        = now;
        r.touched       = touch;
        r.button_click  = click;
        r.gravity_valid = gvalid;
        r.accel_z       = z;
        return r;
    endfunction

    // offer one loop pass, with random sender gaps ahead of it
    task automatic push_item(input item_t pass_item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, pass_item.accel_z, pass_item.button_click,
                     pass_item.touched, pass_item.now_ms};
        s_tuser  <= pass_item.gravity_valid;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // sender holds off until every status word has come back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (tracker.pending() != 0);
    endtask

    // drained and quiet: safe point for register writes
    task automatic wait_idle();
        wait_results();
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    // one register write, enable left high for a following write
    task automatic write_cfg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        tracker.write_reg(idx, val);
    endtask

    // all six registers; narrow ones get random junk above their width
    task automatic apply_config(input cfg_t c);
        logic [31:0] pad;
        pad = $urandom;
        write_cfg(REG_IDLE_TIMEOUT,   c.idle_timeout_ms);
        write_cfg(REG_RAISE_WAKE_EN,  {pad[31:1], c.raise_wake_enable});
        pad = $urandom;
        write_cfg(REG_TILT_PRESENT,   {pad[31:1], c.tilt_sensor_present});
        pad = $urandom;
        write_cfg(REG_RAISE_THRESH,   {pad[31:16], c.raise_threshold});
        pad = $urandom;
        write_cfg(REG_RELEASE_THRESH, {pad[31:16], c.release_threshold});
        pad = $urandom;
        write_cfg(REG_SETTLE_TIME,    {pad[31:16], c.settle_time_ms});
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    task automatic set_pacing(input int mode);
        case (mode)
            PACE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
            PACE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            PACE_BOTH:     begin send_idle_pct = 13; recv_stall_pct = 13; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // register settings per phase: fixed corners first, random ones after
    function automatic cfg_t phase_config(input int p);
        cfg_t c;
        int   rel;
        case (p)
            0: c = '{32'd500, 1'b1, 1'b1, 16'sd8000, 16'sd4000, 16'd100};
            1: c = '{32'd0, 1'b1, 1'b1, -16'sd32768, 16'sd32767, 16'd0};
            2: c = '{32'hFFFF_FFFF, 1'b1, 1'b1, 16'sd32767, -16'sd32768, 16'd65535};
            3: c = '{32'd300, 1'b0, 1'b0, 16'sd2000, 16'sd1000, 16'd40};
            4: c = '{32'd1000, 1'b0, 1'b1, 16'sd0, -16'sd1000, 16'd50};
            5: c = '{32'd1, 1'b1, 1'b1, -16'sd2000, -16'sd6000, 16'd20};
            default: begin
                c.idle_timeout_ms     = ($urandom_range(3) == 0) ? $urandom
                                                                 : $urandom_range(0, 800);
                c.raise_wake_enable   = 1'($urandom_range(1));
                c.tilt_sensor_present = ($urandom_range(3) != 0);
                c.raise_threshold     = 16'($urandom_range(0, 65535));
                if ($urandom_range(3) == 0) begin
                    c.release_threshold = 16'($urandom_range(0, 65535));
                end else begin
                    rel = int'($signed(c.raise_threshold)) - int'($urandom_range(0, 6000));
                    if (rel < -32768)
                        rel = -32768;
                    c.release_threshold = rel[15:0];
                end
                c.settle_time_ms      = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 65535))
                                                                 : 16'($urandom_range(0, 200));
            end
        endcase
        return c;
    endfunction

    // random loop pass: mostly small time steps and a wrist that stays up or down for a while
    task automatic gen_item(output item_t pass_item);
        int r;
        int step;
        int hi;
        int lo;
        int z;
        r = $urandom_range(99);
        if (r < 85)
            clock_ms += $urandom_range(0, 30);
        else if (r < 97)
            clock_ms += $urandom_range(31, 600);
        else
            clock_ms += $urandom;
        if ($urandom_range(99) < 8)
            wrist_up = !wrist_up;
        step = $urandom_range(1, 3000);
        hi   = int'($signed(cur_cfg.raise_threshold)) + step;
        lo   = int'($signed(cur_cfg.release_threshold)) - step;
        if (hi > 32767)
            hi = 32767;
        if (lo < -32768)
            lo = -32768;
        r = $urandom_range(99);
        if (r < 10)
            z = $urandom_range(0, 65535);
        else if (r < 15)
            z = wrist_up ? int'($signed(cur_cfg.raise_threshold))
                         : int'($signed(cur_cfg.release_threshold));
        else
            z = wrist_up ? hi : lo;
        pass_item.now_ms        = clock_ms;
        pass_item.touched       = ($urandom_range(99) < 6);
        pass_item.button_click  = ($urandom_range(99) < 5);
        pass_item.gravity_valid = ($urandom_range(99) < 75);
        pass_item.accel_z       = z[15:0];
    endtask

    // hand-picked passes on the reset settings, then a short timeout, wraparound and no tilt sensor
    task automatic run_directed();
        push_item(make_item(32'd0,   1'b0, 1'b0, 1'b0, 16'h0000));  // nothing happens
        push_item(make_item(32'd10,  1'b0, 1'b0, 1'b1, 16'h7FFF));  // down to settling
        push_item(make_item(32'd100, 1'b0, 1'b0, 1'b1, 16'd8000));  // at raise threshold: down
        push_item(make_item(32'd110, 1'b0, 1'b0, 1'b1, 16'd8001));  // settling again
        push_item(make_item(32'd409, 1'b0, 1'b0, 1'b1, 16'd20000)); // one ms short of settled
        push_item(make_item(32'd410, 1'b0, 1'b0, 1'b1, 16'd20000)); // raised, raise consumed
        push_item(make_item(32'd420, 1'b0, 1'b0, 1'b1, 16'd4000));  // at release: stays raised
        push_item(make_item(32'd430, 1'b0, 1'b0, 1'b1, 16'd3999));  // below release: down
        push_item(make_item(32'd440, 1'b0, 1'b1, 1'b0, 16'h8000));  // button puts to sleep
        push_item(make_item(32'd450, 1'b1, 1'b0, 1'b0, 16'hFFFF));  // touch wakes
        push_item(make_item(32'd460, 1'b1, 1'b1, 1'b0, 16'h0000));  // button beats touch
        push_item(make_item(32'd470, 1'b0, 1'b1, 1'b0, 16'h0000));  // button wakes
        push_item(make_item(32'd30469, 1'b0, 1'b0, 1'b0, 16'h0000)); // one ms before timeout
        push_item(make_item(32'd30470, 1'b0, 1'b0, 1'b0, 16'h0000)); // idle timeout sleeps
        push_item(make_item(32'd30480, 1'b0, 1'b0, 1'b1, 16'd9000));
        push_item(make_item(32'd30780, 1'b0, 1'b0, 1'b1, 16'd9000)); // raise wakes the screen
        push_item(make_item(32'd30790, 1'b0, 1'b0, 1'b1, 16'h8000)); // most negative z
        wait_idle();
        write_cfg(REG_IDLE_TIMEOUT, 32'd100);
        write_cfg(REG_RAISE_WAKE_EN, 32'd0);
        write_cfg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_cfg(REG_SPARE_7, 32'hFFFF_FFFF);
        cfg_wr_en <= 1'b0;
        settings_used++;
        push_item(make_item(32'hFFFF_FFC0, 1'b0, 1'b0, 1'b0, 16'h0000)); // countdown restarts
        push_item(make_item(32'h0000_0020, 1'b0, 1'b0, 1'b1, 16'd30000)); // wrapped, 96 ms idle
        push_item(make_item(32'h0000_0030, 1'b0, 1'b0, 1'b1, 16'd30000)); // 112 ms: sleeps
        push_item(make_item(32'h0000_0150, 1'b0, 1'b0, 1'b1, 16'd30000)); // raise, no wake
        push_item(make_item(32'h0000_0160, 1'b1, 1'b0, 1'b0, 16'h0000));
        wait_idle();
        write_cfg(REG_TILT_PRESENT, 32'd0);
        cfg_wr_en <= 1'b0;
        settings_used++;
        push_item(make_item(32'h0000_0170, 1'b0, 1'b0, 1'b1, 16'h8000)); // detector held
        push_item(make_item(32'h0000_0180, 1'b0, 1'b0, 1'b1, 16'hFFFF));
    endtask

    initial begin
        int    p;
        int    i;
        int    failures;
        item_t pass_item;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // random phases, each with its own settings and pacing
        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_pacing(p % 4);
            apply_config(phase_config(p));
            clock_ms = (p % 2) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20000);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(99) == 0)
                    wait_results();
                gen_item(pass_item);
                push_item(pass_item);
            end
        end

        wait_idle();
        failures = tracker.mismatches + tracker.orphans + tracker.pending();
        $display("ran %0d loop passes under %0d register settings, %0d status words checked",
                 items_sent, settings_used, tracker.checked);
        $display("saw %0d wakes, %0d sleeps and %0d wrist raises; %0d mismatches, %0d unexpected",
                 tracker.wakes, tracker.sleeps, tracker.raises, tracker.mismatches,
                 tracker.orphans);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
